### hdl/sync_crc_frame_parser_macros.svh
// Assertion macros for the sync/CRC frame parser.
// Needs a clk and rst in scope at the point of use.
`ifndef SYNC_CRC_FRAME_PARSER_MACROS_SVH
`define SYNC_CRC_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define SCFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/scfp_pkg.sv
// Shared types and constants for the sync/CRC frame parser.
// No dependencies.
package scfp_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int POS_W       = 7;
  localparam int ADDR_W      = 6;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [7:0] FIRST_SYNC_RST  = 8'hA5;
  localparam logic [7:0] SECOND_SYNC_RST = 8'h5A;

  localparam logic CFG_FIRST_SYNC  = 1'b0;
  localparam logic CFG_SECOND_SYNC = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_SKIP = 3'd1,
    EV_LEN  = 3'd2,
    EV_CRC  = 3'd3,
    EV_GOOD = 3'd4
  } event_t;

  typedef struct packed {
    logic       init;
    logic       start;
    logic [7:0] data;
  } crc_ctrl_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] count;
  } em_start_t;

  typedef struct packed {
    logic              vld;
    logic [7:0]        data;
    logic [ADDR_W-1:0] idx;
    logic              last;
  } em_out_t;

endpackage

### hdl/scfp_crc_serial.sv
// Bit-serial reflected CRC-32: one byte folded in bit by bit.
// Depends on scfp_pkg.
module scfp_crc_serial (
  input  logic                  clk,
  input  logic                  rst,
  input  scfp_pkg::crc_ctrl_t   ctrl,
  output logic [31:0]           crc,
  output logic                  busy
);
  import scfp_pkg::*;

  logic [2:0]  cnt;
  logic [31:0] seed;

  function automatic logic [31:0] crc_bit(input logic [31:0] c);
    crc_bit = {1'b0, c[31:1]} ^ (CRC_POLY & {32{c[0]}});
  endfunction

  assign busy = (cnt != 3'd0);
  assign seed = crc ^ {24'd0, ctrl.data};

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
      cnt <= 3'd0;
    end else if (ctrl.init) begin
      crc <= CRC_INIT;
      cnt <= 3'd0;
    end else if (ctrl.start) begin
      crc <= crc_bit(seed);
      cnt <= 3'd7;
    end else if (busy) begin
      crc <= crc_bit(crc);
      cnt <= cnt - 3'd1;
    end
  end

endmodule

### hdl/scfp_emitter.sv
// Payload buffer and readout sequencer for good frames.
// Depends on scfp_pkg.
module scfp_emitter (
  input  logic                  clk,
  input  logic                  rst,
  input  scfp_pkg::buf_wr_t     wr,
  input  scfp_pkg::em_start_t   go,
  input  logic                  take,
  output scfp_pkg::em_out_t     out,
  output logic                  busy
);
  import scfp_pkg::*;

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_READ = 3'b010,
    E_SHOW = 3'b100
  } em_state_t;

  em_state_t        state, state_next;
  logic [7:0]       mem [MAX_PAYLOAD];
  logic [7:0]       rdata;
  logic [POS_W-1:0] cnt, cnt_next;
  logic [POS_W-1:0] total;
  logic [POS_W-1:0] cnt_inc;
  logic             is_last;

  assign cnt_inc = cnt + POS_W'(1);
  assign is_last = (cnt_inc == total);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (state == E_READ) begin
      rdata <= mem[cnt[ADDR_W-1:0]];
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      E_IDLE: begin
        if (go.start) begin
          state_next = E_READ;
          cnt_next   = '0;
        end
      end
      E_READ: state_next = E_SHOW;
      E_SHOW: begin
        if (take) begin
          if (is_last) begin
            state_next = E_IDLE;
          end else begin
            state_next = E_READ;
            cnt_next   = cnt_inc;
          end
        end
      end
      default: state_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == E_IDLE && go.start) begin
      total <= go.count;
    end
  end

  assign busy     = (state != E_IDLE);
  assign out.vld  = (state == E_SHOW);
  assign out.data = rdata;
  assign out.idx  = cnt[ADDR_W-1:0];
  assign out.last = is_last;

endmodule

### hdl/sync_crc_frame_parser.sv
// Sync/header/CRC-32 deframer: hunts the sync word, checks length and CRC,
// replays good payloads. Each accepted byte gives a registered result word in the
// cycle after, but the last CRC byte of a good non-empty frame starts a replay:
// per payload word the buffer is read, then the word shown until taken. Input
// stalls on the bit-serial CRC loop (header, payload bytes), replay and output.
// Reset (rst, sync) presets CRC, clears phase and counters, not the buffer.
module sync_crc_frame_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [7:0]   cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // rx_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // frame_type, frame_seq, frame_len, payload_byte, payload_index,
  // sync_skip_count, len_error_count, crc_error_count, good_frame_count, pad
  output logic [167:0] m_axis_tdata,
  output logic [3:0]   m_axis_tuser,   // event_res, payload_valid
  output logic         m_axis_tlast
);
  import scfp_pkg::*;

`include "sync_crc_frame_parser_macros.svh"

  typedef enum logic [4:0] {
    PH_SYNC0 = 5'b00001,
    PH_SYNC1 = 5'b00010,
    PH_HDR   = 5'b00100,
    PH_PAY   = 5'b01000,
    PH_CRC   = 5'b10000
  } phase_t;

  logic [7:0]       first_sync, second_sync;
  phase_t           phase, phase_next;
  logic [POS_W-1:0] pos, pos_next, pos_inc;
  logic [7:0]       hdr_type, hdr_type_next, hdr_seq, hdr_seq_next;
  logic [15:0]      hdr_len, hdr_len_next;
  logic [23:0]      rcv_crc, rcv_crc_next;
  logic [31:0]      skips, len_errs, crc_errs, goods;
  logic             inc_skip, inc_len, inc_crc, inc_good;
  logic             res_vld, res_vld_next;
  event_t           res_event, res_event_next;

  crc_ctrl_t        crc_ctrl;
  logic [31:0]      crc_val;
  logic             crc_busy;
  buf_wr_t          buf_wr;
  em_start_t        em_go;
  em_out_t          em_out;
  logic             em_busy;
  logic             em_take;

  logic             accept;
  logic             out_fire;
  logic [7:0]       b;
  logic [6:0]       frame_len;
  logic [7:0]       pay_byte;
  logic [5:0]       pay_idx;

  assign b        = s_axis_tdata;
  assign out_fire = m_axis_tvalid & m_axis_tready;
  assign s_axis_tready = !crc_busy && !em_busy && (!res_vld || m_axis_tready);
  assign accept   = s_axis_tvalid & s_axis_tready;
  assign pos_inc  = pos + POS_W'(1);
  assign em_take  = out_fire && !res_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync  <= FIRST_SYNC_RST;
      second_sync <= SECOND_SYNC_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FIRST_SYNC:  first_sync  <= cfg_data;
        CFG_SECOND_SYNC: second_sync <= cfg_data;
      endcase
    end
  end

  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    hdr_type_next  = hdr_type;
    hdr_seq_next   = hdr_seq;
    hdr_len_next   = hdr_len;
    rcv_crc_next   = rcv_crc;
    inc_skip       = 1'b0;
    inc_len        = 1'b0;
    inc_crc        = 1'b0;
    inc_good       = 1'b0;
    res_event_next = EV_NONE;
    crc_ctrl       = '0;
    crc_ctrl.data  = b;
    buf_wr.en      = 1'b0;
    buf_wr.addr    = pos[ADDR_W-1:0];
    buf_wr.data    = b;
    em_go.start    = 1'b0;
    em_go.count    = hdr_len[POS_W-1:0];
    unique case (phase)
      PH_SYNC0: begin
        if (b == first_sync) begin
          phase_next = PH_SYNC1;
        end else begin
          inc_skip       = 1'b1;
          res_event_next = EV_SKIP;
        end
      end
      PH_SYNC1: begin
        if (b == second_sync) begin
          phase_next    = PH_HDR;
          pos_next      = '0;
          crc_ctrl.init = 1'b1;
        end else if (b != first_sync) begin
          phase_next     = PH_SYNC0;
          inc_skip       = 1'b1;
          res_event_next = EV_SKIP;
        end
      end
      PH_HDR: begin
        crc_ctrl.start = 1'b1;
        case (pos[1:0])
          2'd0:    hdr_type_next = b;
          2'd1:    hdr_seq_next  = b;
          2'd2:    hdr_len_next  = {hdr_len[15:8], b};
          default: hdr_len_next  = {b, hdr_len[7:0]};
        endcase
        pos_next = pos_inc;
        if (pos[1:0] == 2'd3) begin
          pos_next = '0;
          if (hdr_len_next > 16'(MAX_PAYLOAD)) begin
            inc_len        = 1'b1;
            res_event_next = EV_LEN;
            phase_next     = PH_SYNC0;
          end else begin
            phase_next   = (hdr_len_next == 16'd0) ? PH_CRC : PH_PAY;
            rcv_crc_next = '0;
          end
        end
      end
      PH_PAY: begin
        crc_ctrl.start = 1'b1;
        buf_wr.en      = 1'b1;
        pos_next       = pos_inc;
        if (16'(pos_inc) >= hdr_len) begin
          pos_next     = '0;
          rcv_crc_next = '0;
          phase_next   = PH_CRC;
        end
      end
      PH_CRC: begin
        case (pos[1:0])
          2'd0:    rcv_crc_next[7:0]   = b;
          2'd1:    rcv_crc_next[15:8]  = b;
          default: rcv_crc_next[23:16] = b;
        endcase
        pos_next = pos_inc;
        if (pos[1:0] == 2'd3) begin
          pos_next   = '0;
          phase_next = PH_SYNC0;
          if ((crc_val ^ CRC_INIT) != {b, rcv_crc}) begin
            inc_crc        = 1'b1;
            res_event_next = EV_CRC;
          end else begin
            inc_good       = 1'b1;
            res_event_next = EV_GOOD;
            em_go.start    = (hdr_len != 16'd0);
          end
        end
      end
      default: begin
        phase_next = PH_SYNC0;
        pos_next   = '0;
      end
    endcase
    if (!accept) begin
      crc_ctrl.init  = 1'b0;
      crc_ctrl.start = 1'b0;
      buf_wr.en      = 1'b0;
      em_go.start    = 1'b0;
    end
  end

  always_comb begin
    res_vld_next = res_vld && !m_axis_tready;
    if (accept) begin
      res_vld_next = !em_go.start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SYNC0;
      pos      <= '0;
      hdr_type <= '0;
      hdr_seq  <= '0;
      hdr_len  <= '0;
      rcv_crc  <= '0;
      skips    <= '0;
      len_errs <= '0;
      crc_errs <= '0;
      goods    <= '0;
      res_vld  <= 1'b0;
    end else begin
      res_vld <= res_vld_next;
      if (accept) begin
        phase    <= phase_next;
        pos      <= pos_next;
        hdr_type <= hdr_type_next;
        hdr_seq  <= hdr_seq_next;
        hdr_len  <= hdr_len_next;
        rcv_crc  <= rcv_crc_next;
        if (inc_skip) skips    <= skips + 32'd1;
        if (inc_len)  len_errs <= len_errs + 32'd1;
        if (inc_crc)  crc_errs <= crc_errs + 32'd1;
        if (inc_good) goods    <= goods + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_event <= res_event_next;
    end
  end

  scfp_crc_serial u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .crc  (crc_val),
    .busy (crc_busy)
  );

  scfp_emitter u_emit (
    .clk  (clk),
    .rst  (rst),
    .wr   (buf_wr),
    .go   (em_go),
    .take (em_take),
    .out  (em_out),
    .busy (em_busy)
  );

  assign frame_len = (hdr_len > 16'd127) ? 7'd127 : hdr_len[6:0];
  assign pay_byte  = res_vld ? 8'd0 : em_out.data;
  assign pay_idx   = res_vld ? 6'd0 : em_out.idx;

  assign m_axis_tvalid = res_vld || em_out.vld;
  assign m_axis_tlast  = res_vld ? 1'b1 : em_out.last;
  assign m_axis_tuser  = {!res_vld, res_vld ? res_event : EV_GOOD};
  assign m_axis_tdata  = {3'd0, goods, crc_errs, len_errs, skips,
                          pay_idx, pay_byte, frame_len, hdr_seq, hdr_type};

  `SCFP_ASSERT_NOW(a_one_source, res_vld, !em_out.vld, "result and payload both shown")
  `SCFP_ASSERT_NEXT(a_crc_runs, crc_ctrl.start, crc_busy, "CRC loop not started")
  `SCFP_ASSERT_NEXT(a_emit_clear, em_go.start, !res_vld && em_busy, "payload replay start clash")

endmodule

### bench/sync_crc_frame_parser_tb.sv
// Self-checking bench for sync_crc_frame_parser: sync hunt, header, length, CRC-32, replay.
// Builds link byte streams, predicts every output word and checks it field by field.
// Depends on scfp_pkg and the sync_crc_frame_parser RTL.
`timescale 1ns / 1ps

module sync_crc_frame_parser_tb;
  import scfp_pkg::*;

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, IN_HEADER, IN_PAYLOAD, IN_CRC
  } rx_phase_t;

  typedef struct {
    event_t      ev;
    logic [7:0]  ftype;
    logic [7:0]  fseq;
    logic [6:0]  flen;
    logic [7:0]  pbyte;
    logic [5:0]  pidx;
    logic        pvalid;
    logic        plast;
    logic [31:0] n_skip;
    logic [31:0] n_len;
    logic [31:0] n_crc;
    logic [31:0] n_good;
  } out_word_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic         cfg_addr = CFG_FIRST_SYNC;
  logic [7:0]   cfg_data = 8'h00;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;   // rx_byte
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // frame_type, frame_seq, frame_len, payload_byte, payload_index,
  // sync_skip_count, len_error_count, crc_error_count, good_frame_count, pad
  logic [167:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;           // event_res, payload_valid
  logic         m_axis_tlast;

  sync_crc_frame_parser dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #2 clk = ~clk;

  // deframer state as predicted
  logic [7:0]  sync_first = FIRST_SYNC_RST;
  logic [7:0]  sync_second = SECOND_SYNC_RST;
  rx_phase_t   ph = HUNT_FIRST;
  logic [6:0]  byte_pos = '0;
  logic [7:0]  hdr_type = '0;
  logic [7:0]  hdr_seq = '0;
  logic [15:0] hdr_len = '0;
  logic [31:0] crc_acc = CRC_INIT;
  logic [31:0] crc_rx = '0;
  logic [7:0]  pay_mem [64];
  logic [31:0] cnt_skip = '0;
  logic [31:0] cnt_len = '0;
  logic [31:0] cnt_crc = '0;
  logic [31:0] cnt_good = '0;

  out_word_t   pending_words [$];
  int          errors = 0;
  int          bytes_sent = 0;
  int          words_checked = 0;
  int          src_idle_pct = 21;
  int          sink_idle_pct = 60;

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++)
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic void push_word(input event_t ev, input logic [7:0] pb,
                                    input logic [5:0] pi, input logic pv, input logic lst);
    out_word_t w;
    w.ev = ev;
    w.ftype = hdr_type;
    w.fseq = hdr_seq;
    w.flen = (hdr_len > 16'd127) ? 7'd127 : hdr_len[6:0];
    w.pbyte = pb;
    w.pidx = pi;
    w.pvalid = pv;
    w.plast = lst;
    w.n_skip = cnt_skip;
    w.n_len = cnt_len;
    w.n_crc = cnt_crc;
    w.n_good = cnt_good;
    pending_words.push_back(w);
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    event_t ev;
    int n;
    ev = EV_NONE;
    case (ph)
      HUNT_FIRST: begin
        if (b == sync_first) ph = HUNT_SECOND;
        else begin
          cnt_skip++;
          ev = EV_SKIP;
        end
      end
      HUNT_SECOND: begin
        if (b == sync_second) begin
          ph = IN_HEADER;
          byte_pos = '0;
          crc_acc = CRC_INIT;
        end else if (b != sync_first) begin
          ph = HUNT_FIRST;
          cnt_skip++;
          ev = EV_SKIP;
        end
      end
      IN_HEADER: begin
        crc_acc = crc_next(crc_acc, b);
        case (byte_pos[1:0])
          2'd0: hdr_type = b;
          2'd1: hdr_seq = b;
          2'd2: hdr_len[7:0] = b;
          default: hdr_len[15:8] = b;
        endcase
        byte_pos++;
        if (byte_pos >= 7'd4) begin
          byte_pos = '0;
          if (hdr_len > MAX_PAYLOAD) begin
            cnt_len++;
            ev = EV_LEN;
            ph = HUNT_FIRST;
          end else begin
            ph = (hdr_len == 16'd0) ? IN_CRC : IN_PAYLOAD;
            crc_rx = '0;
          end
        end
      end
      IN_PAYLOAD: begin
        crc_acc = crc_next(crc_acc, b);
        pay_mem[byte_pos[5:0]] = b;
        byte_pos++;
        if (byte_pos >= hdr_len) begin
          byte_pos = '0;
          crc_rx = '0;
          ph = IN_CRC;
        end
      end
      IN_CRC: begin
        crc_rx |= {24'd0, b} << (8 * byte_pos[1:0]);
        byte_pos++;
        if (byte_pos >= 7'd4) begin
          byte_pos = '0;
          ph = HUNT_FIRST;
          if (~crc_acc != crc_rx) begin
            cnt_crc++;
            ev = EV_CRC;
          end else begin
            cnt_good++;
            n = int'(hdr_len);
            if (n == 0) push_word(EV_GOOD, 8'd0, 6'd0, 1'b0, 1'b1);
            else
              for (int i = 0; i < n; i++)
                push_word(EV_GOOD, pay_mem[i], i[5:0], 1'b1, i == n - 1);
            return;
          end
        end
      end
      default: begin
        ph = HUNT_FIRST;
        byte_pos = '0;
      end
    endcase
    push_word(ev, 8'd0, 6'd0, 1'b0, 1'b1);
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : check_words
    out_word_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual tdata %0h tuser %0h", $time,
                 m_axis_tdata, m_axis_tuser);
      end else begin
        w = pending_words.pop_front();
        words_checked++;
        check_field("event_res", 32'(w.ev), 32'(m_axis_tuser[2:0]));
        check_field("payload_valid", 32'(w.pvalid), 32'(m_axis_tuser[3]));
        check_field("last", 32'(w.plast), 32'(m_axis_tlast));
        check_field("frame_type", 32'(w.ftype), 32'(m_axis_tdata[7:0]));
        check_field("frame_seq", 32'(w.fseq), 32'(m_axis_tdata[15:8]));
        check_field("frame_len", 32'(w.flen), 32'(m_axis_tdata[22:16]));
        check_field("payload_byte", 32'(w.pbyte), 32'(m_axis_tdata[30:23]));
        check_field("payload_index", 32'(w.pidx), 32'(m_axis_tdata[36:31]));
        check_field("sync_skip_count", w.n_skip, m_axis_tdata[68:37]);
        check_field("len_error_count", w.n_len, m_axis_tdata[100:69]);
        check_field("crc_error_count", w.n_crc, m_axis_tdata[132:101]);
        check_field("good_frame_count", w.n_good, m_axis_tdata[164:133]);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    predict_byte(b);
    bytes_sent++;
  endtask

  // fill < 0 gives random payload; corrupt flips one CRC bit
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] fseq,
                            input logic [15:0] flen, input int fill, input bit corrupt);
    logic [7:0]  bytes [$];
    logic [31:0] c;
    bytes = {sync_first, sync_second, ftype, fseq, flen[7:0], flen[15:8]};
    if (flen <= MAX_PAYLOAD) begin
      for (int i = 0; i < flen; i++)
        bytes.push_back((fill < 0) ? 8'($urandom_range(255)) : fill[7:0]);
      c = CRC_INIT;
      for (int i = 2; i < bytes.size(); i++) c = crc_next(c, bytes[i]);
      c = ~c;
      if (corrupt) c ^= 32'd1 << $urandom_range(31);
      for (int i = 0; i < 4; i++) bytes.push_back(c[8*i +: 8]);
    end
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_sync_bytes(input logic [7:0] a, input logic [7:0] b);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_addr <= CFG_FIRST_SYNC;
    cfg_data <= a;
    @(posedge clk);
    cfg_addr <= CFG_SECOND_SYNC;
    cfg_data <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    sync_first = a;
    sync_second = b;
  endtask

  task automatic test_hunt_skips();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sync_first);
    send_byte(8'h11);
  endtask

  // repeated first sync byte keeps the hunt, then an empty good frame
  task automatic test_empty_frame();
    send_byte(sync_first);
    send_frame(8'h00, 8'hFF, 16'd0, -1, 1'b0);
  endtask

  task automatic test_length_error();
    send_frame(8'hFF, 8'h00, 16'hFFFF, -1, 1'b0);
  endtask

  task automatic test_crc_error();
    send_frame(8'h5C, 8'hA3, 16'd1, 0, 1'b1);
  endtask

  task automatic test_sync_extremes();
    write_sync_bytes(8'h00, 8'hFF);
    send_frame(8'h81, 8'h7E, 16'd64, -1, 1'b0);
    send_frame(8'h01, 8'h02, 16'd2, 255, 1'b0);
  endtask

  // with equal sync bytes the second-byte match wins
  task automatic test_equal_sync();
    write_sync_bytes(8'h3C, 8'h3C);
    send_byte(8'h3C);
    send_byte(8'h00);
    send_frame(8'h3C, 8'h3C, 16'd1, -1, 1'b0);
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int first_byte;
    int r;
    int pick;
    logic [15:0] len;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < n_bytes) begin
      r = $urandom_range(99);
      if (r < 10) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
      end else if (r < 16) begin
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                   16'($urandom_range(65, 16'hFFFF)), -1, 1'b0);
      end else if (r < 22) begin
        send_byte(sync_first);
        send_byte(8'($urandom_range(255)));
      end else begin
        pick = $urandom_range(11);
        if (pick == 0) len = 16'd0;
        else if (pick == 1) len = 16'd64;
        else if (pick == 2) len = 16'($urandom_range(9, 63));
        else len = 16'($urandom_range(1, 8));
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, -1,
                   $urandom_range(5) == 0);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct = 21;
    sink_idle_pct = 60;
    test_hunt_skips();
    test_empty_frame();
    test_length_error();
    test_crc_error();
    test_sync_extremes();
    test_equal_sync();

    write_sync_bytes(FIRST_SYNC_RST, SECOND_SYNC_RST);
    test_random_traffic(95);

    src_idle_pct = 60;
    sink_idle_pct = 21;
    write_sync_bytes(8'hFF, 8'h00);
    test_random_traffic(95);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    write_sync_bytes(8'($urandom_range(255)), 8'($urandom_range(255)));
    test_random_traffic(95);

    wait_idle();
    $display("Sent %0d link bytes and checked %0d output words over several sync byte pairs:",
             bytes_sent, words_checked);
    $display("  %0d good frames, %0d CRC errors, %0d length errors, %0d skipped bytes",
             cnt_good, cnt_crc, cnt_len, cnt_skip);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d words still expected", pending_words.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
